// File: rtl/tle_pkg.sv
package tle_pkg;

    localparam int LINE_MAX = 10;
    localparam int IDX_W    = 4;
    localparam int KEY_W    = 7;
    localparam int COLS_W   = 5;
    localparam int CFG_IDX_W = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_UP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KILL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELETE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SUSPEND = 3'd5;

    // command classes
    localparam logic [3:0] C_CTRLC  = 4'd0;
    localparam logic [3:0] C_ENTER  = 4'd1;
    localparam logic [3:0] C_UP     = 4'd2;
    localparam logic [3:0] C_CANCEL = 4'd3;
    localparam logic [3:0] C_LEFT   = 4'd4;
    localparam logic [3:0] C_RIGHT  = 4'd5;
    localparam logic [3:0] C_KILL   = 4'd6;
    localparam logic [3:0] C_BKSP   = 4'd7;
    localparam logic [3:0] C_DELETE = 4'd8;
    localparam logic [3:0] C_INSERT = 4'd9;

    // result kinds and end statuses
    localparam logic [1:0] K_ECHO = 2'd0;
    localparam logic [1:0] K_LINE = 2'd1;
    localparam logic [1:0] K_END  = 2'd2;
    localparam logic [1:0] ST_ENTER  = 2'd0;
    localparam logic [1:0] ST_CTRLC  = 2'd1;
    localparam logic [1:0] ST_RECALL = 2'd2;

    localparam logic [KEY_W-1:0] CH_CTRLC = 7'h03;
    localparam logic [KEY_W-1:0] CH_CR    = 7'h0D;
    localparam logic [KEY_W-1:0] CH_DEL   = 7'h7F;
    localparam logic [KEY_W-1:0] CH_BS    = 7'h08;
    localparam logic [KEY_W-1:0] CH_CAN   = 7'h18;
    localparam logic [KEY_W-1:0] CH_CAN2  = 7'h15;
    localparam logic [KEY_W-1:0] CH_SPACE = 7'h20;
    localparam logic [KEY_W-1:0] CH_CARET = 7'h5E;
    localparam logic [KEY_W-1:0] CH_C     = 7'h43;
    localparam logic [KEY_W-1:0] CTL_BIT  = 7'h40;

    typedef struct packed {
        logic [3:0]       cls;
        logic [3:0]       alt;
        logic [KEY_W-1:0] key;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] value;
        logic [1:0]       st;
    } t_res;

endpackage

// File: rtl/terminal_line_editor_top.sv
// Line editor with terminal echo. Each accepted keystroke produces zero or more
// results: echo characters (control codes drawn as caret pairs), the finished
// line bytes on Enter, and an end marker with a status; the last result of a
// keystroke carries o_last. The line holds up to LINE_MAX-1 characters. The
// back-end sequencer emits one result per cycle while the output is not stalled
// and moves one stored entry per cycle on insert and delete. A two-deep command
// queue lets up to two keystrokes be taken while an earlier one is still being
// echoed. Key codes are to be written through the configuration port only while
// the block is idle; the block itself does not enforce this.
module terminal_line_editor_top
    import tle_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [KEY_W-1:0]     i_key,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_kind,
    output logic [KEY_W-1:0]     o_value,
    output logic [1:0]           o_end_status,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [KEY_W-1:0]     i_cfg_data
);

    logic w_q_valid, w_q_ready;
    t_cmd w_q_cmd;

    tle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_key      (i_key),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_q_valid  (w_q_valid),
        .i_q_ready  (w_q_ready),
        .o_q_cmd    (w_q_cmd)
    );

    tle_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .o_q_ready    (w_q_ready),
        .i_q_cmd      (w_q_cmd),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_value      (o_value),
        .o_end_status (o_end_status),
        .o_last       (o_last)
    );

endmodule

// File: rtl/tle_front.sv
module tle_front
    import tle_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [KEY_W-1:0]     i_key,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [KEY_W-1:0]     i_cfg_data,
    output logic                 o_q_valid,
    input  logic                 i_q_ready,
    output t_cmd                 o_q_cmd
);

    logic [KEY_W-1:0] r_up, r_left, r_right, r_kill, r_delete, r_suspend;
    t_cmd             r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic [3:0]       w_alt;
    t_cmd             w_cmd;
    logic             w_push, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up      <= 7'd16;
            r_left    <= 7'd2;
            r_right   <= 7'd6;
            r_kill    <= 7'd11;
            r_delete  <= 7'd4;
            r_suspend <= 7'd17;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_UP:      r_up      <= i_cfg_data;
                REG_LEFT:    r_left    <= i_cfg_data;
                REG_RIGHT:   r_right   <= i_cfg_data;
                REG_KILL:    r_kill    <= i_cfg_data;
                REG_DELETE:  r_delete  <= i_cfg_data;
                REG_SUSPEND: r_suspend <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // class a key takes when the ctrl-c branch does not apply
    always_comb begin
        if (i_key == CH_CR)                           w_alt = C_ENTER;
        else if (i_key == r_up)                       w_alt = C_UP;
        else if (i_key == CH_CAN || i_key == CH_CAN2) w_alt = C_CANCEL;
        else if (i_key == r_left)                     w_alt = C_LEFT;
        else if (i_key == r_right)                    w_alt = C_RIGHT;
        else if (i_key == r_kill)                     w_alt = C_KILL;
        else if (i_key == CH_DEL || i_key == CH_BS)   w_alt = C_BKSP;
        else if (i_key == r_delete)                   w_alt = C_DELETE;
        else                                          w_alt = C_INSERT;
        w_cmd.alt = w_alt;
        w_cmd.key = i_key;
        w_cmd.cls = (i_key == CH_CTRLC) ? C_CTRLC : w_alt;
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rp];
    // drop suspend keys at the door
    assign w_push    = i_valid && o_ready && (i_key != r_suspend);
    assign w_pop     = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end

endmodule

// File: rtl/tle_back.sv
module tle_back
    import tle_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_q_ready,
    input  t_cmd             i_q_cmd,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_kind,
    output logic [KEY_W-1:0] o_value,
    output logic [1:0]       o_end_status,
    output logic             o_last
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CC    = 4'd1;
    localparam logic [3:0] S_LINE  = 4'd2;
    localparam logic [3:0] S_END   = 4'd3;
    localparam logic [3:0] S_BACK  = 4'd4;
    localparam logic [3:0] S_SHOW  = 4'd5;
    localparam logic [3:0] S_SPACE = 4'd6;
    localparam logic [3:0] S_BSN   = 4'd7;
    localparam logic [3:0] S_DCAP  = 4'd8;
    localparam logic [3:0] S_SHDN  = 4'd9;
    localparam logic [3:0] S_DPAD  = 4'd10;
    localparam logic [3:0] S_SHUP  = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    logic [KEY_W-1:0]  r_store [LINE_MAX];
    logic [3:0]        r_st, n_st;
    logic [3:0]        r_cmd, n_cmd;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [KEY_W-1:0]  r_c, n_c;
    logic [IDX_W-1:0]  r_i, n_i, r_hi, n_hi, r_cur, n_cur, r_len, n_len;
    logic [COLS_W-1:0] r_cols, n_cols;
    logic [1:0]        r_ph, n_ph, r_endst, n_endst;
    logic              r_half, n_half, r_tail, n_tail;

    t_res              r_hold, r_out;
    logic              r_hold_v, r_out_v, r_out_last;

    logic [IDX_W-1:0]  w_raddr, w_waddr;
    logic [KEY_W-1:0]  w_rd, w_wdata;
    logic              w_we, w_ctl, w_cctl;
    logic              w_emit, w_flush, w_can, w_out_free;
    t_res              w_e;
    logic [3:0]        w_cls;

    assign w_out_free = !r_out_v || i_ready;
    assign w_can      = !r_hold_v || w_out_free;

    always_comb begin
        if (r_st == S_SHDN)      w_raddr = r_i + 4'd1;
        else if (r_st == S_SHUP) w_raddr = r_i - 4'd1;
        else                     w_raddr = r_i;
    end
    assign w_rd   = (w_raddr < IDX_W'(LINE_MAX)) ? r_store[w_raddr] : '0;
    assign w_ctl  = (w_rd[6:5] == 2'b00);
    assign w_cctl = (r_c[6:5] == 2'b00);
    assign w_cls  = (i_q_cmd.cls == C_CTRLC && r_len != '0) ? i_q_cmd.alt : i_q_cmd.cls;

    always_comb begin
        n_st = r_st; n_cmd = r_cmd; n_key = r_key; n_c = r_c;
        n_i = r_i; n_hi = r_hi; n_cur = r_cur; n_len = r_len;
        n_cols = r_cols; n_ph = r_ph; n_endst = r_endst;
        n_half = r_half; n_tail = r_tail;
        o_q_ready = 1'b0;
        w_emit = 1'b0; w_flush = 1'b0;
        w_e = '{kind: K_ECHO, value: CH_BS, st: ST_ENTER};
        w_we = 1'b0; w_waddr = r_i; w_wdata = w_rd;
        unique case (r_st)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_ready = 1'b1;
                    n_cmd  = w_cls;
                    n_key  = i_q_cmd.key;
                    n_tail = 1'b0;
                    n_half = 1'b0;
                    n_st   = S_FIN;
                    unique case (w_cls)
                        C_CTRLC: n_st = S_CC;
                        C_ENTER: begin
                            n_i = '0; n_st = S_LINE;
                        end
                        C_UP, C_CANCEL: begin
                            n_i = '0; n_hi = r_cur; n_st = S_BACK;
                        end
                        C_LEFT, C_BKSP: begin
                            if (r_cur != '0) begin
                                n_i = r_cur - 4'd1; n_hi = r_cur; n_st = S_BACK;
                            end
                        end
                        C_RIGHT: begin
                            if (r_cur < r_len) begin
                                n_i = r_cur; n_hi = r_cur + 4'd1; n_st = S_SHOW;
                            end
                        end
                        C_KILL: begin
                            n_i = r_cur; n_hi = r_len; n_cols = '0; n_st = S_SPACE;
                        end
                        C_DELETE: begin
                            if (r_cur < r_len) begin
                                n_i = r_cur; n_st = S_DCAP;
                            end
                        end
                        C_INSERT: begin
                            if ({1'b0, r_len} + 5'd1 < 5'(LINE_MAX)) begin
                                n_i = r_len; n_st = S_SHUP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CC: begin
                w_emit = 1'b1;
                w_e.value = r_half ? CH_C : CH_CARET;
                if (w_can) begin
                    if (r_half) begin
                        n_half = 1'b0; n_endst = ST_CTRLC; n_st = S_END;
                    end else begin
                        n_half = 1'b1;
                    end
                end
            end
            S_LINE: begin
                if (r_i < r_len) begin
                    w_emit = 1'b1;
                    w_e.kind = K_LINE; w_e.value = w_rd;
                    if (w_can) n_i = r_i + 4'd1;
                end else begin
                    n_endst = ST_ENTER; n_st = S_END;
                end
            end
            S_END: begin
                w_emit = 1'b1;
                w_e.kind = K_END; w_e.value = '0; w_e.st = r_endst;
                if (w_can) begin
                    n_cur = '0; n_len = '0; n_st = S_FIN;
                end
            end
            S_BACK: begin
                if (r_i < r_hi) begin
                    w_emit = 1'b1;
                    if (w_can) begin
                        if (w_ctl && !r_half) n_half = 1'b1;
                        else begin
                            n_half = 1'b0; n_i = r_i + 4'd1;
                        end
                    end
                end else if (r_tail) begin
                    n_st = S_FIN;
                end else begin
                    n_st = S_FIN;
                    case (r_cmd)
                        C_UP, C_CANCEL: begin
                            n_cur = '0; n_i = '0; n_hi = r_len; n_cols = '0;
                            n_st = S_SPACE;
                        end
                        C_LEFT: n_cur = r_cur - 4'd1;
                        C_BKSP: begin
                            n_cur = r_cur - 4'd1; n_i = r_cur - 4'd1; n_st = S_DCAP;
                        end
                        default: ;
                    endcase
                end
            end
            S_SHOW: begin
                if (r_i < r_hi) begin
                    w_emit = 1'b1;
                    w_e.value = w_ctl ? (r_half ? (w_rd | CTL_BIT) : CH_CARET) : w_rd;
                    if (w_can) begin
                        if (w_ctl && !r_half) n_half = 1'b1;
                        else begin
                            n_half = 1'b0; n_i = r_i + 4'd1;
                        end
                    end
                end else begin
                    case (r_cmd)
                        C_RIGHT: begin
                            n_cur = r_cur + 4'd1; n_st = S_FIN;
                        end
                        C_INSERT: begin
                            n_cur = r_cur + 4'd1; n_i = r_cur + 4'd1; n_hi = r_len;
                            n_tail = 1'b1; n_st = S_BACK;
                        end
                        default: begin
                            n_ph = w_cctl ? 2'd0 : 2'd1; n_st = S_DPAD;
                        end
                    endcase
                end
            end
            S_SPACE: begin
                if (r_i < r_hi) begin
                    w_emit = 1'b1;
                    w_e.value = CH_SPACE;
                    if (w_can) begin
                        n_cols = r_cols + 5'd1;
                        if (w_ctl && !r_half) n_half = 1'b1;
                        else begin
                            n_half = 1'b0; n_i = r_i + 4'd1;
                        end
                    end
                end else begin
                    n_st = S_BSN;
                end
            end
            S_BSN: begin
                if (r_cols != '0) begin
                    w_emit = 1'b1;
                    if (w_can) n_cols = r_cols - 5'd1;
                end else begin
                    n_len = r_cur;
                    if (r_cmd == C_UP) begin
                        n_endst = ST_RECALL; n_st = S_END;
                    end else begin
                        n_st = S_FIN;
                    end
                end
            end
            S_DCAP: begin
                n_c = w_rd; n_st = S_SHDN;
            end
            S_SHDN: begin
                // close the gap one entry a cycle
                if ({1'b0, r_i} + 5'd1 < {1'b0, r_len}) begin
                    w_we = 1'b1; w_waddr = r_i; w_wdata = w_rd;
                    n_i = r_i + 4'd1;
                end else begin
                    n_len = r_len - 4'd1; n_i = r_cur; n_hi = r_len - 4'd1;
                    n_half = 1'b0; n_st = S_SHOW;
                end
            end
            S_DPAD: begin
                w_emit = 1'b1;
                w_e.value = (r_ph < 2'd2) ? CH_SPACE : CH_BS;
                if (w_can) begin
                    if (r_ph == 2'd3) begin
                        n_i = r_cur; n_hi = r_len; n_tail = 1'b1; n_half = 1'b0;
                        n_st = S_BACK;
                    end else begin
                        n_ph = r_ph + (w_cctl ? 2'd1 : 2'd2);
                    end
                end
            end
            S_SHUP: begin
                // open a gap at the cursor one entry a cycle
                if (r_i != r_cur) begin
                    w_we = 1'b1; w_waddr = r_i; w_wdata = w_rd;
                    n_i = r_i - 4'd1;
                end else begin
                    w_we = 1'b1; w_waddr = r_cur; w_wdata = r_key;
                    n_len = r_len + 4'd1; n_i = r_cur; n_hi = r_len + 4'd1;
                    n_half = 1'b0; n_st = S_SHOW;
                end
            end
            S_FIN: begin
                if (!r_hold_v) n_st = S_IDLE;
                else if (w_out_free) begin
                    w_flush = 1'b1; n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cur <= '0; r_len <= '0;
            r_hold_v <= 1'b0; r_out_v <= 1'b0;
        end else begin
            r_st <= n_st; r_cur <= n_cur; r_len <= n_len;
            if (r_out_v && i_ready) r_out_v <= 1'b0;
            if (w_emit && w_can) begin
                if (r_hold_v) r_out_v <= 1'b1;
                r_hold_v <= 1'b1;
            end else if (w_flush) begin
                r_out_v <= 1'b1; r_hold_v <= 1'b0;
            end
        end
    end

    // hold the newest result back in a holding register so its last flag is known
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_key <= n_key; r_c <= n_c; r_i <= n_i; r_hi <= n_hi;
        r_cols <= n_cols; r_ph <= n_ph; r_endst <= n_endst;
        r_half <= n_half; r_tail <= n_tail;
        if (w_emit && w_can) begin
            if (r_hold_v) begin
                r_out <= r_hold; r_out_last <= 1'b0;
            end
            r_hold <= w_e;
        end else if (w_flush) begin
            r_out <= r_hold; r_out_last <= 1'b1;
        end
        if (w_we) r_store[w_waddr] <= w_wdata;
    end

    assign o_valid      = r_out_v;
    assign o_kind       = r_out.kind;
    assign o_value      = r_out.value;
    assign o_end_status = r_out.st;
    assign o_last       = r_out_last;

    a_cur_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= r_len) else $error("cursor past line end");
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len < IDX_W'(LINE_MAX)) else $error("line length overflow");
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.kind == K_END |-> r_out_last)
        else $error("end marker not final");
    a_idle_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_IDLE |-> !r_hold_v) else $error("held result left behind");

endmodule
